// ----- hw/rtl/motion_wake_mode_controller_assert.svh -----
// assertion macros for the motion wake mode controller
// expects clk_i and rst_ni in the scope of each use
`ifndef MOTION_WAKE_MODE_CONTROLLER_ASSERT_SVH
`define MOTION_WAKE_MODE_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MWMC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MWMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mwmc_pkg.sv -----
// shared types and codes for the motion wake mode controller
// no dependencies
package mwmc_pkg;

  // result mode codes
  localparam logic [1:0] MODE_WAITING  = 2'd0;
  localparam logic [1:0] MODE_INITIAL  = 2'd1;
  localparam logic [1:0] MODE_POINTING = 2'd2;

  // result event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_INITIAL  = 3'd1;
  localparam logic [2:0] EV_POINTING = 3'd2;
  localparam logic [2:0] EV_WAITING  = 3'd3;
  localparam logic [2:0] EV_HUE      = 3'd4;

  // config register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] REG_MOTION_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_INITIAL_MOVE_MS  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SLEEP_AFTER_MS   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_HUE_PERIOD_MS    = 2'd3;

  // config reset values
  localparam logic [14:0] RST_MOTION_THRESHOLD = 15'd30;
  localparam logic [15:0] RST_INITIAL_MOVE_MS  = 16'd2000;
  localparam logic [15:0] RST_SLEEP_AFTER_MS   = 16'd3000;
  localparam logic [15:0] RST_HUE_PERIOD_MS    = 16'd10000;

  typedef enum logic [2:0] {
    ST_WAITING  = 3'b001,
    ST_INITIAL  = 3'b010,
    ST_POINTING = 3'b100
  } mode_state_e;

  typedef struct packed {
    logic        [31:0] now_ms;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] hue;
    logic       moved;
    logic [2:0] event_res;
  } out_beat_t;

  typedef struct packed {
    logic [14:0] motion_threshold;
    logic [15:0] initial_move_ms;
    logic [15:0] sleep_after_ms;
    logic [15:0] hue_period_ms;
  } cfg_t;

  typedef struct packed {
    mode_state_e        mode;
    logic signed [15:0] ref_x;
    logic signed [15:0] ref_y;
    logic signed [15:0] ref_z;
    logic        [31:0] mark_time;
    logic        [7:0]  hue;
  } ctx_t;

endpackage

// ----- hw/rtl/motion_wake_mode_controller.sv -----
// an accepted input beat passes through the input reg and then the result reg to result valid
// throughput: one beat per cycle, sustained while the result side keeps up
// the mode/timer/reference state updates as a beat moves into the result reg
// reset: waiting mode, zero reference, zero mark time, zero hue, config defaults
// top level of the motion wake mode controller; uses mwmc_pkg, mwmc_step
// and the assertion macros in motion_wake_mode_controller_assert.svh
`include "motion_wake_mode_controller_assert.svh"

module motion_wake_mode_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [mwmc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mwmc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // sample beats in
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  mwmc_pkg::in_beat_t               in_beat_i,
  // result beats out
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output mwmc_pkg::out_beat_t              out_beat_o
);
  import mwmc_pkg::*;

  // config registers
  cfg_t cfg_q;

  // input register
  logic     in_valid_q;
  in_beat_t in_beat_q;

  // block state and result register
  ctx_t      ctx_q, ctx_d;
  logic      out_valid_q;
  out_beat_t out_beat_q, res_d;

  logic advance;
  logic in_accept;

  // the input beat moves into the result reg when that reg is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  // input reg holds off only while its beat is blocked
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motion_threshold <= RST_MOTION_THRESHOLD;
      cfg_q.initial_move_ms  <= RST_INITIAL_MOVE_MS;
      cfg_q.sleep_after_ms   <= RST_SLEEP_AFTER_MS;
      cfg_q.hue_period_ms    <= RST_HUE_PERIOD_MS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MOTION_THRESHOLD: cfg_q.motion_threshold <= cfg_wdata_i[14:0];
        REG_INITIAL_MOVE_MS:  cfg_q.initial_move_ms  <= cfg_wdata_i;
        REG_SLEEP_AFTER_MS:   cfg_q.sleep_after_ms   <= cfg_wdata_i;
        REG_HUE_PERIOD_MS:    cfg_q.hue_period_ms    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_beat_q <= in_beat_i;
    end
  end

  mwmc_step u_step (
    .cfg_i  (cfg_q),
    .ctx_i  (ctx_q),
    .beat_i (in_beat_q),
    .ctx_o  (ctx_d),
    .res_o  (res_d)
  );

  // state commits as the beat enters the result reg
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.mode      <= ST_WAITING;
      ctx_q.ref_x     <= '0;
      ctx_q.ref_y     <= '0;
      ctx_q.ref_z     <= '0;
      ctx_q.mark_time <= '0;
      ctx_q.hue       <= '0;
    end else if (advance) begin
      ctx_q <= ctx_d;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_beat_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // motion only ever starts initial move or restarts the pointing timer
  `MWMC_ASSERT_IMPL(a_moved_event, out_valid_q && out_beat_q.moved, out_beat_q.event_res == EV_INITIAL || out_beat_q.event_res == EV_NONE, "motion with unexpected event")
  // a hue step happens only in waiting
  `MWMC_ASSERT_IMPL(a_hue_in_waiting, out_valid_q && out_beat_q.event_res == EV_HUE, out_beat_q.mode == MODE_WAITING, "hue step outside waiting")
  // a committed beat always shows up in the result reg
  `MWMC_ASSERT_NEXT(a_advance_fills, advance, out_valid_q, "result reg not filled")
  // hue register changes only on a hue step
  `MWMC_ASSERT_NEXT(a_hue_hold, !advance || res_d.event_res != EV_HUE, $stable(ctx_q.hue), "hue moved without hue step")
  // input side only stalls with a beat held
  `MWMC_ASSERT_IMPL(a_stall_needs_beat, in_stall_o, in_valid_q, "stall without held beat")

endmodule

// ----- hw/rtl/mwmc_step.sv -----
// next-state and result logic for one sample beat
// depends on mwmc_pkg
module mwmc_step (
  input  mwmc_pkg::cfg_t     cfg_i,
  input  mwmc_pkg::ctx_t     ctx_i,
  input  mwmc_pkg::in_beat_t beat_i,
  output mwmc_pkg::ctx_t     ctx_o,
  output mwmc_pkg::out_beat_t res_o
);
  import mwmc_pkg::*;

  logic signed [16:0] diff_x, diff_y, diff_z;
  logic        [16:0] mag_x, mag_y, mag_z;
  logic        [16:0] thr_ext;
  logic               motion;
  logic        [31:0] elapsed;
  logic               init_done, sleep_done, hue_due;

  // per-axis difference in 17 bits, then magnitude compare
  assign diff_x = {beat_i.accel_x[15], beat_i.accel_x} - {ctx_i.ref_x[15], ctx_i.ref_x};
  assign diff_y = {beat_i.accel_y[15], beat_i.accel_y} - {ctx_i.ref_y[15], ctx_i.ref_y};
  assign diff_z = {beat_i.accel_z[15], beat_i.accel_z} - {ctx_i.ref_z[15], ctx_i.ref_z};
  assign mag_x  = diff_x[16] ? 17'(-diff_x) : 17'(diff_x);
  assign mag_y  = diff_y[16] ? 17'(-diff_y) : 17'(diff_y);
  assign mag_z  = diff_z[16] ? 17'(-diff_z) : 17'(diff_z);
  assign thr_ext = {2'b00, cfg_i.motion_threshold};
  assign motion = (mag_x >= thr_ext) || (mag_y >= thr_ext) || (mag_z >= thr_ext);

  // elapsed time modulo 2^32
  assign elapsed    = beat_i.now_ms - ctx_i.mark_time;
  assign init_done  = elapsed >= {16'd0, cfg_i.initial_move_ms};
  assign sleep_done = elapsed >= {16'd0, cfg_i.sleep_after_ms};
  assign hue_due    = elapsed >= {16'd0, cfg_i.hue_period_ms};

  always_comb begin
    logic moved;
    logic [2:0] ev;
    moved = 1'b0;
    ev    = EV_NONE;
    ctx_o = ctx_i;
    unique case (ctx_i.mode)
      ST_INITIAL: begin
        // no motion check in initial move
        if (init_done) begin
          ctx_o.mode      = ST_POINTING;
          ctx_o.mark_time = beat_i.now_ms;
          ev              = EV_POINTING;
        end
      end
      ST_POINTING: begin
        moved = motion;
        if (motion) begin
          ctx_o.mark_time = beat_i.now_ms;
        end else if (sleep_done) begin
          ctx_o.mode      = ST_WAITING;
          ctx_o.mark_time = beat_i.now_ms;
          ev              = EV_WAITING;
        end
      end
      default: begin
        ctx_o.mode = ST_WAITING;
        moved      = motion;
        if (motion) begin
          ctx_o.mode      = ST_INITIAL;
          ctx_o.mark_time = beat_i.now_ms;
          ev              = EV_INITIAL;
        end else if (hue_due) begin
          ctx_o.hue       = ctx_i.hue + 8'd1;
          ctx_o.mark_time = beat_i.now_ms;
          ev              = EV_HUE;
        end
      end
    endcase
    // reference follows the sample on motion
    if (moved) begin
      ctx_o.ref_x = beat_i.accel_x;
      ctx_o.ref_y = beat_i.accel_y;
      ctx_o.ref_z = beat_i.accel_z;
    end
    unique case (ctx_o.mode)
      ST_INITIAL:  res_o.mode = MODE_INITIAL;
      ST_POINTING: res_o.mode = MODE_POINTING;
      default:     res_o.mode = MODE_WAITING;
    endcase
    res_o.hue       = ctx_o.hue;
    res_o.moved     = moved;
    res_o.event_res = ev;
  end

endmodule
